### rtl/sorted_array_priority_queue_defines.svh
// Assertion helpers for the queue RTL
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_DEFINES_SVH

// Checked only while out of reset
`define SPQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### rtl/spq_pkg.sv
`default_nettype none

package spq_pkg;

    localparam int DEPTH_DEF          = 64;
    localparam int VALUE_WIDTH_DEF    = 32;
    localparam int PRIORITY_WIDTH_DEF = 16;

    // fixed field widths on the stream ports
    localparam int VALUE_FW  = 32;
    localparam int PRIO_FW   = 16;
    localparam int COUNT_FW  = 7;
    localparam int STATUS_FW = 2;

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 64;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_spq_cmd;

    typedef enum logic [STATUS_FW-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_spq_status;

    // shift command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic rem;
    } t_spq_op;

endpackage

`default_nettype wire

### rtl/sorted_array_priority_queue.sv
// A result is offered in the cycle after its item is accepted.
// Throughput: one item per cycle while results are taken; the whole row of
// cells shifts at once, so a stalled result holds off the input.
// Reset: clears the entry count and the result valid; slot contents stay
// undefined and are never shown before being written.
`default_nettype none

`include "sorted_array_priority_queue_defines.svh"

module sorted_array_priority_queue #(
    parameter int DEPTH          = spq_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH    = spq_pkg::VALUE_WIDTH_DEF,
    parameter int PRIORITY_WIDTH = spq_pkg::PRIORITY_WIDTH_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // slave side
    input  wire                            i_s_tvalid,
    output logic                           o_s_tready,
    input  wire  [spq_pkg::S_DATA_W-1:0]   i_s_tdata,  // item_value[31:0], item_priority[47:32]
    input  wire                            i_s_tuser,  // cmd
    // master side
    output logic                           o_m_tvalid,
    input  wire                            i_m_tready,
    // top_value[31:0], top_priority[47:32], is_empty[48], is_full[49],
    // entry_count[56:50], zero[63:57]
    output logic [spq_pkg::M_DATA_W-1:0]   o_m_tdata,
    output logic [spq_pkg::STATUS_FW-1:0]  o_m_tuser   // status
);

    localparam int CW = $clog2(DEPTH + 1);

    logic                     r_out_valid, n_out_valid;
    logic [CW-1:0]            r_count, n_count;
    spq_pkg::t_spq_status     r_status, n_status;

    logic                     w_accept, w_full, w_empty;
    spq_pkg::t_spq_cmd        w_cmd;
    spq_pkg::t_spq_op         w_op;
    logic [VALUE_WIDTH-1:0]   w_new_value;
    logic [PRIORITY_WIDTH-1:0] w_new_prio;

    logic                      w_keep [DEPTH];
    logic [VALUE_WIDTH-1:0]    w_val  [DEPTH];
    logic [PRIORITY_WIDTH-1:0] w_prio [DEPTH];

    assign o_s_tready  = i_rst_n && (!r_out_valid || i_m_tready);
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_cmd       = spq_pkg::t_spq_cmd'(i_s_tuser);
    assign w_new_value = VALUE_WIDTH'(i_s_tdata[spq_pkg::VALUE_FW-1:0]);
    assign w_new_prio  = PRIORITY_WIDTH'(
                             i_s_tdata[spq_pkg::VALUE_FW +: spq_pkg::PRIO_FW]);
    assign w_full      = (r_count == CW'(DEPTH));
    assign w_empty     = (r_count == '0);

    assign w_op.ins = w_accept && (w_cmd == spq_pkg::CMD_INSERT) && !w_full;
    assign w_op.rem = w_accept && (w_cmd == spq_pkg::CMD_REMOVE) && !w_empty;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic                      w_pkeep;
            logic [VALUE_WIDTH-1:0]    w_pval,  w_nval;
            logic [PRIORITY_WIDTH-1:0] w_pprio, w_nprio;

            if (gi == 0) begin : g_head
                assign w_pkeep = 1'b1;
                assign w_pval  = w_new_value;
                assign w_pprio = w_new_prio;
            end else begin : g_body
                assign w_pkeep = w_keep[gi-1];
                assign w_pval  = w_val[gi-1];
                assign w_pprio = w_prio[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_tail
                assign w_nval  = w_val[gi];
                assign w_nprio = w_prio[gi];
            end else begin : g_mid
                assign w_nval  = w_val[gi+1];
                assign w_nprio = w_prio[gi+1];
            end

            spq_cell #(
                .VALUE_WIDTH    (VALUE_WIDTH),
                .PRIORITY_WIDTH (PRIORITY_WIDTH)
            ) u_cell (
                .i_clk        (i_clk),
                .i_op         (w_op),
                .i_occupied   (r_count > CW'(gi)),
                .i_new_value  (w_new_value),
                .i_new_prio   (w_new_prio),
                .i_prev_keep  (w_pkeep),
                .i_prev_value (w_pval),
                .i_prev_prio  (w_pprio),
                .i_next_value (w_nval),
                .i_next_prio  (w_nprio),
                .o_keep       (w_keep[gi]),
                .o_value      (w_val[gi]),
                .o_prio       (w_prio[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count     = r_count;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        if (w_op.ins) begin
            n_count = r_count + 1'b1;
        end else if (w_op.rem) begin
            n_count = r_count - 1'b1;
        end
        if (w_accept) begin
            n_out_valid = 1'b1;
            if (w_cmd == spq_pkg::CMD_INSERT && w_full) begin
                n_status = spq_pkg::ST_FULL;
            end else if (w_cmd == spq_pkg::CMD_REMOVE && w_empty) begin
                n_status = spq_pkg::ST_EMPTY;
            end else begin
                n_status = spq_pkg::ST_DONE;
            end
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
        end
        r_status <= n_status;
    end

    // result reads the settled cell row; top is slot 0
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = {
        {(spq_pkg::M_DATA_W - spq_pkg::VALUE_FW - spq_pkg::PRIO_FW - 2
          - spq_pkg::COUNT_FW){1'b0}},
        spq_pkg::COUNT_FW'(r_count),
        w_full,
        w_empty,
        (w_empty ? {spq_pkg::PRIO_FW{1'b0}} : spq_pkg::PRIO_FW'(w_prio[0])),
        (w_empty ? {spq_pkg::VALUE_FW{1'b0}} : spq_pkg::VALUE_FW'(w_val[0]))
    };

    `SPQ_ASSERT(a_count_bound, r_count <= CW'(DEPTH), "entry count above depth")
    `SPQ_ASSERT(a_ins_count, w_op.ins |=> r_count == $past(r_count) + 1'b1, "insert count step")
    `SPQ_ASSERT(a_stall_hold, (r_out_valid && !i_m_tready) |=> $stable(r_count),
                "queue moved under stall")
    `SPQ_ASSERT(a_full_drop,
                (w_accept && w_cmd == spq_pkg::CMD_INSERT && w_full) |=>
                (r_status == spq_pkg::ST_FULL && $stable(r_count)),
                "full insert not dropped")

endmodule

`default_nettype wire

### rtl/spq_cell.sv
`default_nettype none

// One slot of the sorted row; slot 0 is the top of the queue.
module spq_cell #(
    parameter int VALUE_WIDTH    = spq_pkg::VALUE_WIDTH_DEF,
    parameter int PRIORITY_WIDTH = spq_pkg::PRIORITY_WIDTH_DEF
) (
    input  wire                        i_clk,
    input  wire spq_pkg::t_spq_op      i_op,
    input  wire                        i_occupied,
    input  wire  [VALUE_WIDTH-1:0]     i_new_value,
    input  wire  [PRIORITY_WIDTH-1:0]  i_new_prio,
    input  wire                        i_prev_keep,
    input  wire  [VALUE_WIDTH-1:0]     i_prev_value,
    input  wire  [PRIORITY_WIDTH-1:0]  i_prev_prio,
    input  wire  [VALUE_WIDTH-1:0]     i_next_value,
    input  wire  [PRIORITY_WIDTH-1:0]  i_next_prio,
    output logic                       o_keep,
    output logic [VALUE_WIDTH-1:0]     o_value,
    output logic [PRIORITY_WIDTH-1:0]  o_prio
);

    logic [VALUE_WIDTH-1:0]    r_value, n_value;
    logic [PRIORITY_WIDTH-1:0] r_prio,  n_prio;

    // an equal priority stays ahead of the new entry
    assign o_keep  = i_occupied && (r_prio >= i_new_prio);
    assign o_value = r_value;
    assign o_prio  = r_prio;

    always_comb begin
        n_value = r_value;
        n_prio  = r_prio;
        if (i_op.ins && !o_keep) begin
            if (i_prev_keep) begin
                n_value = i_new_value;
                n_prio  = i_new_prio;
            end else begin
                n_value = i_prev_value;
                n_prio  = i_prev_prio;
            end
        end else if (i_op.rem) begin
            n_value = i_next_value;
            n_prio  = i_next_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_prio  <= n_prio;
    end

endmodule

`default_nettype wire

### test/sorted_array_priority_queue_test.sv
`timescale 1ns / 1ps

module sorted_array_priority_queue_test;

    localparam int QDEPTH = spq_pkg::DEPTH_DEF;

    typedef struct {
        spq_pkg::t_spq_cmd cmd;
        logic [31:0]       value;
        logic [15:0]       prio;
        bit                drain_first;  // hold back until every outstanding result is in
    } t_queue_cmd;

    // laid out as {o_m_tdata, o_m_tuser}
    typedef struct packed {
        logic [6:0]           pad;
        logic [6:0]           count;
        logic                 full;
        logic                 empty;
        logic [15:0]          top_prio;
        logic [31:0]          top_value;
        spq_pkg::t_spq_status status;
    } t_queue_view;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    wire                            s_tready;
    logic [spq_pkg::S_DATA_W-1:0]   s_tdata = '0;   // item_value[31:0], item_priority[47:32]
    logic                           s_tuser = 1'b0; // cmd
    wire                            m_tvalid;
    logic                           m_tready = 1'b0;
    // top_value[31:0], top_priority[47:32], is_empty[48], is_full[49],
    // entry_count[56:50], zero[63:57]
    wire  [spq_pkg::M_DATA_W-1:0]   m_tdata;
    wire  [spq_pkg::STATUS_FW-1:0]  m_tuser;        // status

    sorted_array_priority_queue dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // shadow queue
    // ---------------------------------------------------------------
    logic [31:0] shadow_val [QDEPTH];
    logic [15:0] shadow_pri [QDEPTH];
    int          shadow_held = 0;

    t_queue_cmd  pending_cmds[$];
    t_queue_view expected_views[$];
    int          mismatches = 0;

    function automatic t_queue_view apply_cmd(t_queue_cmd c);
        t_queue_view v;
        int pos;
        v = '0;
        v.status = spq_pkg::ST_DONE;
        if (c.cmd == spq_pkg::CMD_INSERT) begin
            if (shadow_held >= QDEPTH) begin
                v.status = spq_pkg::ST_FULL;
            end else begin
                // equal priorities stay above the newcomer, so ties leave in arrival order
                pos = shadow_held;
                while (pos > 0 && shadow_pri[pos-1] >= c.prio) begin
                    shadow_val[pos] = shadow_val[pos-1];
                    shadow_pri[pos] = shadow_pri[pos-1];
                    pos--;
                end
                shadow_val[pos] = c.value;
                shadow_pri[pos] = c.prio;
                shadow_held++;
            end
        end else if (shadow_held == 0) begin
            v.status = spq_pkg::ST_EMPTY;
        end else begin
            shadow_held--;
        end
        if (shadow_held > 0) begin
            v.top_value = shadow_val[shadow_held-1];
            v.top_prio  = shadow_pri[shadow_held-1];
        end
        v.empty = (shadow_held == 0);
        v.full  = (shadow_held == QDEPTH);
        v.count = 7'(shadow_held);
        return v;
    endfunction

    task automatic add_cmd(spq_pkg::t_spq_cmd cmd, logic [31:0] value, logic [15:0] prio,
                           bit drain_first);
        t_queue_cmd c;
        c.cmd         = cmd;
        c.value       = value;
        c.prio        = prio;
        c.drain_first = drain_first;
        pending_cmds.push_back(c);
    endtask

    function automatic logic [15:0] pick_prio();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel < 4)
            return 16'($urandom_range(0, 7));           // dense, lots of ties
        else if (sel == 4)
            return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        else
            return 16'($urandom);
    endfunction

    task automatic mismatch(string what, t_queue_view want, t_queue_view got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s: exp st=%0d val=%h pri=%h e=%b f=%b cnt=%0d pad=%h",
                     $realtime, what,
                     want.status, want.top_value, want.top_prio, want.empty, want.full,
                     want.count, want.pad);
            $display("    got st=%0d val=%h pri=%h e=%b f=%b cnt=%0d pad=%h",
                     got.status, got.top_value, got.top_prio, got.empty, got.full,
                     got.count, got.pad);
        end
    endtask

    // ---------------------------------------------------------------
    // driver: bursts of beats with random gaps
    // ---------------------------------------------------------------
    t_queue_cmd in_flight;
    int         gap_left = 0;
    int         burst_left = 0;

    always @(posedge clk) begin
        t_queue_cmd nxt;
        if (!rst_n) begin
            s_tvalid   <= 1'b0;
            gap_left   <= 0;
            burst_left <= 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_views.push_back(apply_cmd(in_flight));
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_cmds.size() != 0 &&
                             !(pending_cmds[0].drain_first && expected_views.size() != 0)) begin
                    nxt = pending_cmds.pop_front();
                    in_flight <= nxt;
                    s_tdata   <= {nxt.prio, nxt.value};
                    s_tuser   <= nxt.cmd;
                    s_tvalid  <= 1'b1;
                    if (burst_left <= 1) begin
                        gap_left   <= $urandom_range(1, 6);
                        burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(150, 400)
                                                                  : $urandom_range(1, 20);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // receiver back-pressure: randomly chosen modes pick the pattern of ready and stall cycles
    // ---------------------------------------------------------------
    int       rx_mode = 0;
    int       rx_left = 0;
    logic [1:0] rx_phase = '0;

    always @(posedge clk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(50, 300);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_phase <= rx_phase + 2'd1;
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (rx_phase == 2'd0);
            default: m_tready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    // ---------------------------------------------------------------
    // monitor
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        t_queue_view got;
        t_queue_view want;
        if (rst_n && m_tvalid && m_tready) begin
            got = t_queue_view'({m_tdata, m_tuser});
            if (expected_views.size() == 0) begin
                mismatch("result beat with nothing outstanding", '0, got);
            end else begin
                want = expected_views.pop_front();
                if (got.status !== want.status || got.top_value !== want.top_value ||
                    got.top_prio !== want.top_prio || got.empty !== want.empty ||
                    got.full !== want.full || got.count !== want.count ||
                    got.pad !== want.pad)
                    mismatch("result beat differs", want, got);
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus and end of run
    // ---------------------------------------------------------------
    initial begin
        int ins_pct;
        int seg_len;
        int total;
        int phase;

        // remove on empty, junk in the ignored fields
        add_cmd(spq_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        add_cmd(spq_pkg::CMD_INSERT, 32'h0000_0000, 16'h0000, 1'b0);
        add_cmd(spq_pkg::CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        // tie at the top goes below the older entry
        add_cmd(spq_pkg::CMD_INSERT, 32'h0000_0001, 16'hFFFF, 1'b0);
        // tie at the bottom
        add_cmd(spq_pkg::CMD_INSERT, 32'h1234_5678, 16'h0000, 1'b0);
        add_cmd(spq_pkg::CMD_INSERT, 32'hA5A5_5A5A, 16'h8000, 1'b0);
        add_cmd(spq_pkg::CMD_INSERT, 32'h5A5A_A5A5, 16'h7FFF, 1'b0);
        repeat (6) add_cmd(spq_pkg::CMD_REMOVE, $urandom, 16'($urandom), 1'b0);
        add_cmd(spq_pkg::CMD_REMOVE, 32'h0, 16'h0, 1'b0);
        // new entry that belongs at the very bottom
        add_cmd(spq_pkg::CMD_INSERT, 32'hDEAD_BEEF, 16'h0005, 1'b0);
        add_cmd(spq_pkg::CMD_INSERT, 32'hCAFE_F00D, 16'h0001, 1'b0);
        add_cmd(spq_pkg::CMD_INSERT, 32'h0BAD_CAFE, 16'h0003, 1'b0);
        repeat (3) add_cmd(spq_pkg::CMD_REMOVE, $urandom, 16'($urandom), 1'b0);
        add_cmd(spq_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);

        // random part: alternate filling, draining and balanced stretches so the
        // queue regularly hits both full and empty
        total = 0;
        phase = 0;
        while (total < 1500) begin
            case (phase % 3)
                0: ins_pct = 85;
                1: ins_pct = 15;
                default: ins_pct = 50;
            endcase
            seg_len = $urandom_range(90, 160);
            for (int i = 0; i < seg_len; i++) begin
                add_cmd(($urandom_range(0, 99) < ins_pct) ? spq_pkg::CMD_INSERT
                                                          : spq_pkg::CMD_REMOVE,
                        $urandom, pick_prio(),
                        (i == 0) && (total == 0 || $urandom_range(0, 3) == 0));
            end
            total += seg_len;
            phase++;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // checked away from the rising edge so the driver's updates have settled
        while (pending_cmds.size() != 0 || s_tvalid || expected_views.size() != 0)
            @(negedge clk);
        repeat (20) @(posedge clk);
        mismatches += expected_views.size();

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
